// ===== rtl/core/rgbabox_pkg.sv =====
// Package with the constants, types and helper functions of the RGBA 2x2 box downscaler.
package rgbabox_pkg;

	localparam int MAX_LINE_PIXELS = 512;
	localparam int MAX_FRAME_LINES = 2048;
	localparam int LINE_ENTRIES = MAX_LINE_PIXELS / 2;
	localparam int PIX_BYTES = 4;

	localparam int COL_W = $clog2(MAX_LINE_PIXELS);
	localparam int ROW_W = $clog2(MAX_FRAME_LINES);
	localparam int WIDTH_W = 10;
	localparam int HEIGHT_W = 12;
	localparam int IDX_W = $clog2(LINE_ENTRIES);
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = HEIGHT_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 10'd480;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd800;

	typedef logic [PIX_BYTES-1:0][7:0] pixel_t;
	typedef logic [PIX_BYTES-1:0][8:0] pair_sum_t;
	typedef logic [PIX_BYTES-1:0][9:0] quad_sum_t;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		r = w;
		if (w < WIDTH_W'(2)) begin
			r = WIDTH_W'(2);
		end else if (w > WIDTH_W'(MAX_LINE_PIXELS)) begin
			r = WIDTH_W'(MAX_LINE_PIXELS);
		end
		return r;
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] r;
		r = h;
		if (h < HEIGHT_W'(2)) begin
			r = HEIGHT_W'(2);
		end else if (h > HEIGHT_W'(MAX_FRAME_LINES)) begin
			r = HEIGHT_W'(MAX_FRAME_LINES);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/rgba_2x2_box_downscaler.sv =====
// Top level of the RGBA 2x2 box downscaler with its line buffer and two-stage datapath.
// An output word passes the read stage and then the output register after the odd-row pixel that completes its block.
// Throughput: one input pixel per cycle while pixel_stall is low; the line buffer has one write and one read port.
// The input is stalled only while both the read stage and the output register hold words.
// Reset clears the counters, the held pixel, the valid flags and sets the sizes to 480x800.
// The line buffer is not cleared; each entry is written on an even row before it is read.
module rgba_2x2_box_downscaler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgbabox_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rgbabox_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                 pixel_valid,
	output logic                                 pixel_stall,
	input  logic [7:0]                           pixel_byte0,
	input  logic [7:0]                           pixel_byte1,
	input  logic [7:0]                           pixel_byte2,
	input  logic [7:0]                           pixel_byte3,
	output logic                                 avg_valid,
	input  logic                                 avg_stall,
	output logic [7:0]                           avg_byte0,
	output logic [7:0]                           avg_byte1,
	output logic [7:0]                           avg_byte2,
	output logic [7:0]                           avg_byte3,
	output logic                                 frame_end
);
	import rgbabox_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	pixel_t              left_q;
	pair_sum_t           line_mem [LINE_ENTRIES];

	pixel_t              pix;
	pair_sum_t           pair_sum;
	logic [WIDTH_W-1:0]  width_even;
	logic [HEIGHT_W-1:0] height_even;
	logic [IDX_W-1:0]    idx;
	logic                accept;
	logic                pair_in_width;
	logic                mem_we;
	logic                emit_now;
	logic                last_pair;
	logic                en1;
	logic                en2;

	logic                v_s1;
	pair_sum_t           below_s1;
	pair_sum_t           above_s1;
	logic                fe_s1;

	quad_sum_t           quad_sum;
	logic                v_s2;
	pixel_t              avg_s2;
	logic                fe_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:   width_q  <= clamp_width(cfg_data[WIDTH_W-1:0]);
				CFG_FRAME_HEIGHT: height_q <= clamp_height(cfg_data);
				default: ;
			endcase
		end
	end

	assign en2 = !v_s2 || !avg_stall;
	assign en1 = !v_s1 || en2;
	assign pixel_stall = !en1;
	assign accept = pixel_valid && !pixel_stall;

	assign pix = {pixel_byte3, pixel_byte2, pixel_byte1, pixel_byte0};
	assign width_even = {width_q[WIDTH_W-1:1], 1'b0};
	assign height_even = {height_q[HEIGHT_W-1:1], 1'b0};
	assign idx = col_q[COL_W-1:1];

	always_comb begin
		for (int i = 0; i < PIX_BYTES; i++) begin
			pair_sum[i] = {1'b0, left_q[i]} + {1'b0, pix[i]};
		end
	end

	assign pair_in_width = col_q[0] && ({1'b0, col_q} < width_even);
	assign mem_we = accept && pair_in_width && !row_q[0];
	assign emit_now = accept && pair_in_width && row_q[0] && ({1'b0, row_q} < height_even);
	assign last_pair = ({1'b0, row_q} == height_even - HEIGHT_W'(1))
		&& ({1'b0, col_q} == width_even - WIDTH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				left_q <= pix;
			end
			if (({1'b0, col_q} + WIDTH_W'(1)) >= width_q) begin
				col_q <= '0;
				if (({1'b0, row_q} + HEIGHT_W'(1)) >= height_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[idx] <= pair_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			above_s1 <= line_mem[idx];
			below_s1 <= pair_sum;
			fe_s1    <= last_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= emit_now;
		end
	end

	always_comb begin
		for (int i = 0; i < PIX_BYTES; i++) begin
			quad_sum[i] = {1'b0, above_s1[i]} + {1'b0, below_s1[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < PIX_BYTES; i++) begin
				avg_s2[i] <= quad_sum[i][9:2];
			end
			fe_s2 <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	assign avg_valid = v_s2;
	assign avg_byte0 = avg_s2[0];
	assign avg_byte1 = avg_s2[1];
	assign avg_byte2 = avg_s2[2];
	assign avg_byte3 = avg_s2[3];
	assign frame_end = fe_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (v_s1 && v_s2 && avg_stall))
		else $error("input stalled while the pipeline has room");

	a_emit_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now |=> v_s1)
		else $error("emitting pixel did not enter the read stage");

	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en2) |=> avg_valid)
		else $error("read stage word lost on its way to the output");

	a_no_write_on_odd_row: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !emit_now)
		else $error("line buffer written and read for output in the same cycle");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGBA 2x2 box downscaler with a built-in pixel predictor.
module tb;
	import rgbabox_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PIPE_SETTLE = 4;
	localparam int RANDOM_WORDS = 200;
	localparam int MAX_SHOWN = 50;

	typedef struct {
		pixel_t avg;
		logic   last;
	} avg_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [7:0] pixel_byte0 = '0;
	logic [7:0] pixel_byte1 = '0;
	logic [7:0] pixel_byte2 = '0;
	logic [7:0] pixel_byte3 = '0;
	logic avg_valid;
	logic avg_stall = 1'b0;
	logic [7:0] avg_byte0;
	logic [7:0] avg_byte1;
	logic [7:0] avg_byte2;
	logic [7:0] avg_byte3;
	logic frame_end;

	rgba_2x2_box_downscaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_byte0(pixel_byte0),
		.pixel_byte1(pixel_byte1),
		.pixel_byte2(pixel_byte2),
		.pixel_byte3(pixel_byte3),
		.avg_valid(avg_valid),
		.avg_stall(avg_stall),
		.avg_byte0(avg_byte0),
		.avg_byte1(avg_byte1),
		.avg_byte2(avg_byte2),
		.avg_byte3(avg_byte3),
		.frame_end(frame_end)
	);

	// Predictor state mirrors the block's registers, counters and line of pair sums.
	logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	int column_pos = 0;
	int row_pos = 0;
	pixel_t left_pixel = '0;
	pair_sum_t line_sums [LINE_ENTRIES];
	avg_word_t expected_avgs [$];

	int error_count = 0;
	int cycle_count = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_long_hold = 0;

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_SHOWN) begin
			$display("ERROR %0t ns: %s", $time, what);
		end
	endtask

	function automatic int eff_width();
		int w;
		w = width_reg;
		if (w < 2) begin
			w = 2;
		end else if (w > MAX_LINE_PIXELS) begin
			w = MAX_LINE_PIXELS;
		end
		return w;
	endfunction

	function automatic int eff_height();
		int h;
		h = height_reg;
		if (h < 2) begin
			h = 2;
		end else if (h > MAX_FRAME_LINES) begin
			h = MAX_FRAME_LINES;
		end
		return h;
	endfunction

	// Even rows store horizontal pair sums; odd rows inside the even part emit the block mean.
	function automatic void predict_pixel(input pixel_t px);
		int w;
		int h;
		int w_even;
		int h_even;
		int idx;
		pair_sum_t sums;
		pair_sum_t above;
		logic [9:0] quad;
		avg_word_t want;
		w = eff_width();
		h = eff_height();
		w_even = w & ~1;
		h_even = h & ~1;
		if (column_pos % 2 == 0) begin
			left_pixel = px;
		end else if (column_pos < w_even) begin
			idx = (column_pos >> 1) % LINE_ENTRIES;
			for (int i = 0; i < PIX_BYTES; i++) begin
				sums[i] = left_pixel[i] + px[i];
			end
			if (row_pos % 2 == 0) begin
				line_sums[idx] = sums;
			end else if (row_pos < h_even) begin
				above = line_sums[idx];
				for (int i = 0; i < PIX_BYTES; i++) begin
					quad = above[i] + sums[i];
					want.avg[i] = quad[9:2];
				end
				want.last = (row_pos == h_even - 1) && (column_pos == w_even - 1);
				expected_avgs.push_back(want);
			end
		end
		column_pos++;
		if (column_pos >= w) begin
			column_pos = 0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
			end
		end
	endfunction

	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_byte0 <= px[0];
		pixel_byte1 <= px[1];
		pixel_byte2 <= px[2];
		pixel_byte3 <= px[3];
		do @(posedge clk); while (pixel_stall);
		predict_pixel(px);
	endtask

	task automatic send_random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			send_pixel(pixel_t'($urandom()));
		end
	endtask

	// The block may still hold a pixel that yields nothing, so a PIPE_SETTLE wait follows the last word.
	task automatic drain_results();
		pixel_valid <= 1'b0;
		while (expected_avgs.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_LINE_WIDTH) begin
			width_reg = data[WIDTH_W-1:0];
		end else begin
			height_reg = data;
		end
	endtask

	task automatic set_sizes(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		write_reg(CFG_LINE_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
	endtask

	task automatic test_byte_extremes();
		set_sizes(12'd2, 12'd2);
		repeat (4) send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hB3_01_FF_00);
		send_pixel(32'h00_01_FF_00);
		send_pixel(32'h80_01_FF_00);
		send_pixel(32'h7F_00_FE_00);
	endtask

	task automatic test_clamped_sizes();
		set_sizes(12'd0, 12'd1);
		send_random_pixels(4);
	endtask

	task automatic test_odd_sizes();
		set_sizes(12'd5, 12'd3);
		send_random_pixels(15);
	endtask

	// One even line at the widest setting writes every entry of the line buffer.
	task automatic test_widest_line();
		set_sizes(12'hFFF, 12'd2);
		send_random_pixels(MAX_LINE_PIXELS);
	endtask

	task automatic test_size_change_mid_frame();
		set_sizes(12'd16, 12'd4);
		send_random_pixels(12);
		write_reg(CFG_LINE_WIDTH, 12'd8);
		send_random_pixels(30);
		write_reg(CFG_FRAME_HEIGHT, 12'd1);
		send_random_pixels(20);
	endtask

	task automatic test_random_sizes();
		int sent;
		int total;
		int n;
		logic [WIDTH_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0: w = WIDTH_W'($urandom_range(0, 1));
				1: w = WIDTH_W'(MAX_LINE_PIXELS);
				2: w = WIDTH_W'($urandom_range(513, 1023));
				3: w = WIDTH_W'($urandom_range(21, 511));
				default: w = WIDTH_W'($urandom_range(2, 20));
			endcase
			case ($urandom_range(0, 9))
				0: h = CFG_DATA_W'($urandom_range(0, 1));
				1: h = CFG_DATA_W'(MAX_FRAME_LINES);
				2: h = 12'hFFF;
				3: h = CFG_DATA_W'($urandom_range(10, 64));
				default: h = CFG_DATA_W'($urandom_range(2, 9));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(CFG_LINE_WIDTH, {2'($urandom()), w});
				1: write_reg(CFG_FRAME_HEIGHT, h);
				default: set_sizes({2'($urandom()), w}, h);
			endcase
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			total = eff_width() * eff_height();
			if (total > 300) begin
				n = $urandom_range(20, 100);
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, total);
			end else begin
				n = total;
			end
			send_random_pixels(n);
			sent += n;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// The receiver holds off long enough for the output to fill and stall the input.
	task automatic test_output_backpressure();
		set_sizes(12'd8, 12'd64);
		tx_idle_on = 1'b0;
		rx_long_hold = 200;
		send_random_pixels(128);
		tx_idle_on = 1'b1;
	endtask

	initial begin
		int hold;
		forever begin
			if (rx_long_hold > 0) begin
				hold = rx_long_hold;
				rx_long_hold = 0;
			end else begin
				hold = rx_idle_on ? $urandom_range(0, 8) : 0;
			end
			if (hold > 0) begin
				avg_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			avg_stall <= 1'b0;
			do @(posedge clk); while (!avg_valid && rx_long_hold == 0);
		end
	end

	initial begin
		avg_word_t want;
		pixel_t got;
		forever begin
			@(posedge clk);
			if (arst_n && avg_valid && !avg_stall) begin
				got = {avg_byte3, avg_byte2, avg_byte1, avg_byte0};
				if (expected_avgs.size() == 0) begin
					report_mismatch($sformatf("unexpected output word %h", got));
				end else begin
					want = expected_avgs.pop_front();
					for (int i = 0; i < PIX_BYTES; i++) begin
						if (got[i] !== want.avg[i]) begin
							report_mismatch($sformatf("avg_byte%0d is %h, expected %h",
								i, got[i], want.avg[i]));
						end
					end
					if (frame_end !== want.last) begin
						report_mismatch($sformatf("frame_end is %b, expected %b",
							frame_end, want.last));
					end
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_extremes();
		test_clamped_sizes();
		test_odd_sizes();
		test_widest_line();
		test_size_change_mid_frame();
		test_random_sizes();
		test_output_backpressure();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_avgs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
